// ===== src/csvs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvs_pkg
// Types and constants shared by the CSV field splitter modules.
// ----------------------------------------------------------------------------
package csvs_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_FEND = 2'd1;
    localparam logic [1:0] KIND_LEND = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FIELD_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BYTE_BUDGET = 2'd1;

    localparam logic [7:0]  FIELD_LIMIT_RST = 8'd32;
    localparam logic [15:0] BYTE_BUDGET_RST = 16'd4096;

    typedef enum logic [2:0] {
        M_START  = 3'd0,
        M_PLAIN  = 3'd1,
        M_QUOTED = 3'd2,
        M_QSEEN  = 3'd3,
        M_SKIP   = 3'd4,
        M_STOP   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] field_index;
        logic [7:0] field_count;
    } t_result;

    // up to three results caused by one input word, packed from res0 upward
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
        t_result    res2;
    } t_bundle;

endpackage

// ===== src/csvs_parser.sv =====
// ----------------------------------------------------------------------------
// csvs_parser
// Line parse state and the per-byte step: turns one accepted byte into a
// bundle of up to three results and advances mode, field and byte counts.
// ----------------------------------------------------------------------------
module csvs_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_line_byte,
    input  logic             i_line_last,
    input  logic [7:0]       i_field_limit,
    input  logic [15:0]      i_byte_budget,
    output csvs_pkg::t_bundle o_bundle
);

    csvs_pkg::t_mode r_mode;
    csvs_pkg::t_mode n_mode;
    logic [7:0]      r_opened;
    logic [7:0]      n_opened;
    logic [15:0]     r_used;
    logic [15:0]     n_used;

    // step decode
    csvs_pkg::t_mode step_mode;
    logic [7:0]      step_opened;
    logic            act_store;
    logic            act_end;
    logic [7:0]      store_byte;
    logic            can_store;
    logic            can_open;
    logic            can_term;
    logic            tail_end;
    logic [7:0]      field_idx;

    csvs_pkg::t_result cand_step;
    csvs_pkg::t_result cand_fend;
    csvs_pkg::t_result cand_lend;

    assign can_store = ({1'b0, r_used} + 17'd1) < {1'b0, i_byte_budget};
    assign can_term  = r_used < i_byte_budget;
    assign can_open  = (r_opened < i_field_limit) && can_store;

    // decide what this byte does within the line
    always_comb begin
        step_mode   = r_mode;
        step_opened = r_opened;
        act_store   = 1'b0;
        act_end     = 1'b0;
        store_byte  = i_line_byte;
        case (r_mode)
            csvs_pkg::M_START: begin
                if (can_open) begin
                    step_opened = r_opened + 8'd1;
                    if (i_line_byte == csvs_pkg::CH_QUOTE) begin
                        step_mode = csvs_pkg::M_QUOTED;
                    end else if (i_line_byte == csvs_pkg::CH_COMMA) begin
                        act_end = 1'b1;
                    end else begin
                        step_mode = csvs_pkg::M_PLAIN;
                        act_store = 1'b1;
                    end
                end else begin
                    step_mode = csvs_pkg::M_STOP;
                end
            end
            csvs_pkg::M_PLAIN: begin
                if (i_line_byte == csvs_pkg::CH_COMMA) begin
                    act_end = 1'b1;
                end else begin
                    act_store = 1'b1;
                end
            end
            csvs_pkg::M_QUOTED: begin
                if (i_line_byte == csvs_pkg::CH_QUOTE) begin
                    step_mode = csvs_pkg::M_QSEEN;
                end else begin
                    act_store = 1'b1;
                end
            end
            csvs_pkg::M_QSEEN: begin
                if (i_line_byte == csvs_pkg::CH_QUOTE) begin
                    act_store  = 1'b1;
                    store_byte = csvs_pkg::CH_QUOTE;
                    step_mode  = csvs_pkg::M_QUOTED;
                end else if (i_line_byte == csvs_pkg::CH_COMMA) begin
                    act_end = 1'b1;
                end else begin
                    step_mode = csvs_pkg::M_SKIP;
                end
            end
            csvs_pkg::M_SKIP: begin
                if (i_line_byte == csvs_pkg::CH_COMMA) begin
                    act_end = 1'b1;
                end
            end
            default: begin
                step_mode = csvs_pkg::M_STOP;
            end
        endcase
        if (act_end) begin
            step_mode = csvs_pkg::M_START;
        end
    end

    // an open field at line end is closed before the line end
    assign tail_end = i_line_last && (step_mode inside {csvs_pkg::M_PLAIN,
        csvs_pkg::M_QUOTED, csvs_pkg::M_QSEEN, csvs_pkg::M_SKIP});

    // next state
    always_comb begin
        n_mode   = step_mode;
        n_opened = step_opened;
        n_used   = r_used;
        if ((act_store && can_store) || (act_end && can_term)) begin
            n_used = r_used + 16'd1;
        end
        if (i_line_last) begin
            n_mode   = csvs_pkg::M_START;
            n_opened = 8'd0;
            n_used   = 16'd0;
        end
    end

    // results
    assign field_idx = step_opened - 8'd1;

    always_comb begin
        logic p0;
        p0 = (act_store && can_store) || act_end;

        cand_step.kind        = act_end ? csvs_pkg::KIND_FEND : csvs_pkg::KIND_DATA;
        cand_step.data_byte   = act_end ? 8'd0 : store_byte;
        cand_step.field_index = field_idx;
        cand_step.field_count = 8'd0;

        cand_fend.kind        = csvs_pkg::KIND_FEND;
        cand_fend.data_byte   = 8'd0;
        cand_fend.field_index = field_idx;
        cand_fend.field_count = 8'd0;

        cand_lend.kind        = csvs_pkg::KIND_LEND;
        cand_lend.data_byte   = 8'd0;
        cand_lend.field_index = 8'd0;
        cand_lend.field_count = step_opened;

        // a tail field end only comes with a line end, so pack toward res0
        o_bundle.res0 = p0 ? cand_step : (tail_end ? cand_fend : cand_lend);
        o_bundle.res1 = p0 ? (tail_end ? cand_fend : cand_lend) : cand_lend;
        o_bundle.res2 = cand_lend;
        o_bundle.cnt  = {1'b0, p0} + {1'b0, tail_end} + {1'b0, i_line_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= csvs_pkg::M_START;
            r_opened <= 8'd0;
            r_used   <= 16'd0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_opened <= n_opened;
            r_used   <= n_used;
        end
    end

endmodule

// ===== src/csv_field_splitter.sv =====
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a CSV line, one byte per input word, into field data, field end and
// line end result words.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry i_line_byte and i_line_last; the
// line comes without its end-of-line characters, line_last marks its final
// byte. Output channel: o_valid / i_stall carry one result word per cycle unless stalled:
// o_kind (data byte, field end, line end), o_data_byte, o_field_index,
// o_field_count, and o_last on the final result caused by one input byte.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_idx
// (0 field limit, 1 byte budget); write only while the block is idle.
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver does not stall; a byte that causes several results holds
// the input until its last word leaves, because the result buffer drains one
// word per cycle unless stalled. A byte that causes no result does not hold it.
// Reset: parse state returns to field start with zero fields and bytes used,
// the result buffer empties and the registers take 32 and 4096.
// Receiver stall: the current result word holds; the input is stalled until
// the buffer is down to the word being taken.
// ----------------------------------------------------------------------------
module csv_field_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_line_byte,
    input  logic        i_line_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_field_index,
    output logic [7:0]  o_field_count,
    output logic        o_last
);

    logic [7:0]        r_field_limit;
    logic [15:0]       r_byte_budget;
    csvs_pkg::t_result r_q [3];
    logic [1:0]        r_cnt;

    csvs_pkg::t_bundle bundle;
    logic              accept;
    logic              take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_limit <= csvs_pkg::FIELD_LIMIT_RST;
            r_byte_budget <= csvs_pkg::BYTE_BUDGET_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx == csvs_pkg::CFG_FIELD_LIMIT) begin
                r_field_limit <= i_cfg_data[7:0];
            end else if (i_cfg_idx == csvs_pkg::CFG_BYTE_BUDGET) begin
                r_byte_budget <= i_cfg_data;
            end
        end
    end

    assign take    = (r_cnt != 2'd0) && !i_stall;
    // take a new byte once the buffer is empty or its last word leaves now
    assign o_stall = !((r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall));
    assign accept  = i_valid && !o_stall;

    csvs_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_line_byte   (i_line_byte),
        .i_line_last   (i_line_last),
        .i_field_limit (r_field_limit),
        .i_byte_budget (r_byte_budget),
        .o_bundle      (bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_cnt <= bundle.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // payload: load a fresh bundle or advance by one word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[0] <= bundle.res0;
            r_q[1] <= bundle.res1;
            r_q[2] <= bundle.res2;
        end else if (take) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    assign o_valid       = r_cnt != 2'd0;
    assign o_last        = r_cnt == 2'd1;
    assign o_kind        = r_q[0].kind;
    assign o_data_byte   = r_q[0].data_byte;
    assign o_field_index = r_q[0].field_index;
    assign o_field_count = r_q[0].field_count;

endmodule

// ===== verif/csv_split_checker.sv =====
// ----------------------------------------------------------------------------
// csv_split_checker
// Watches the byte and result channels of the CSV field splitter, predicts
// the data, field end and line end words of each accepted byte and compares
// every accepted result word against the oldest predicted word.
// ----------------------------------------------------------------------------
module csv_split_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_line_byte,
    input  logic        i_line_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_field_index,
    input  logic [7:0]  i_field_count,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] field_index;
        logic [7:0] field_count;
        logic       last;
    } t_split_word;

    t_split_word split_q[$];
    t_split_word byte_words[3];
    int          word_cnt;
    int          fail_cnt = 0;

    // predictor copy of the registers and the parse state
    logic [7:0]      field_limit = csvs_pkg::FIELD_LIMIT_RST;
    logic [15:0]     byte_budget = csvs_pkg::BYTE_BUDGET_RST;
    csvs_pkg::t_mode mode        = csvs_pkg::M_START;
    logic [7:0]      fields_open = 8'd0;
    logic [15:0]     bytes_used  = 16'd0;

    function automatic void put_word(logic [1:0] kind, logic [7:0] data,
                                     logic [7:0] idx, logic [7:0] count);
        byte_words[word_cnt] = '{kind, data, idx, count, 1'b0};
        word_cnt++;
    endfunction

    // budget test is signed: a budget of 0 or 1 leaves no room at all
    function automatic bit data_room();
        return int'(bytes_used) < int'(byte_budget) - 1;
    endfunction

    function automatic void keep_byte(logic [7:0] b);
        if (data_room()) begin
            bytes_used++;
            put_word(csvs_pkg::KIND_DATA, b, 8'(fields_open - 8'd1), 8'd0);
        end
    endfunction

    function automatic void close_field();
        if (bytes_used < byte_budget)
            bytes_used++;
        put_word(csvs_pkg::KIND_FEND, 8'd0, 8'(fields_open - 8'd1), 8'd0);
        mode = csvs_pkg::M_START;
    endfunction

    function automatic void split_byte(logic [7:0] b, logic line_last);
        word_cnt = 0;
        case (mode)
            csvs_pkg::M_START: begin
                if (fields_open < field_limit && data_room()) begin
                    fields_open++;
                    if (b == csvs_pkg::CH_QUOTE) begin
                        mode = csvs_pkg::M_QUOTED;
                    end else if (b == csvs_pkg::CH_COMMA) begin
                        close_field();
                    end else begin
                        mode = csvs_pkg::M_PLAIN;
                        keep_byte(b);
                    end
                end else begin
                    mode = csvs_pkg::M_STOP;
                end
            end
            csvs_pkg::M_PLAIN: begin
                if (b == csvs_pkg::CH_COMMA)
                    close_field();
                else
                    keep_byte(b);
            end
            csvs_pkg::M_QUOTED: begin
                if (b == csvs_pkg::CH_QUOTE)
                    mode = csvs_pkg::M_QSEEN;
                else
                    keep_byte(b);
            end
            csvs_pkg::M_QSEEN: begin
                if (b == csvs_pkg::CH_QUOTE) begin
                    keep_byte(csvs_pkg::CH_QUOTE);
                    mode = csvs_pkg::M_QUOTED;
                end else if (b == csvs_pkg::CH_COMMA) begin
                    close_field();
                end else begin
                    mode = csvs_pkg::M_SKIP;
                end
            end
            csvs_pkg::M_SKIP: begin
                if (b == csvs_pkg::CH_COMMA)
                    close_field();
            end
            default: mode = csvs_pkg::M_STOP;
        endcase
        if (line_last) begin
            // close a field still open when the line ends
            if (mode == csvs_pkg::M_PLAIN || mode == csvs_pkg::M_QUOTED ||
                mode == csvs_pkg::M_QSEEN || mode == csvs_pkg::M_SKIP)
                close_field();
            put_word(csvs_pkg::KIND_LEND, 8'd0, 8'd0, fields_open);
            mode        = csvs_pkg::M_START;
            fields_open = 8'd0;
            bytes_used  = 16'd0;
        end
    endfunction

    function automatic int field_bad(string name, int want, int got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_split_word want;
        int          k;
        int          bad;
        if (!i_rst_n) begin
            field_limit = csvs_pkg::FIELD_LIMIT_RST;
            byte_budget = csvs_pkg::BYTE_BUDGET_RST;
            mode        = csvs_pkg::M_START;
            fields_open = 8'd0;
            bytes_used  = 16'd0;
            split_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == csvs_pkg::CFG_FIELD_LIMIT)
                    field_limit = i_cfg_data[7:0];
                else if (i_cfg_idx == csvs_pkg::CFG_BYTE_BUDGET)
                    byte_budget = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                split_byte(i_line_byte, i_line_last);
                for (k = 0; k < word_cnt; k++) begin
                    want      = byte_words[k];
                    want.last = (k == word_cnt - 1);
                    split_q.push_back(want);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (split_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual kind %0d",
                             $time, i_kind);
                    fail_cnt++;
                end else begin
                    want = split_q.pop_front();
                    bad  = field_bad("kind", int'(want.kind), int'(i_kind));
                    bad += field_bad("data_byte", int'(want.data_byte),
                                     int'(i_data_byte));
                    bad += field_bad("field_index", int'(want.field_index),
                                     int'(i_field_index));
                    bad += field_bad("field_count", int'(want.field_count),
                                     int'(i_field_count));
                    bad += field_bad("last", int'(want.last), int'(i_last));
                    fail_cnt += bad;
                end
            end
        end
        o_pending    <= split_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== verif/csv_field_splitter_tb.sv =====
// ----------------------------------------------------------------------------
// csv_field_splitter_tb
// Feeds CSV lines byte by byte into the field splitter under changing field
// limits and byte budgets: a few hand-picked lines first, then random lines
// built mostly from plain and quoted fields. Sender and receiver idle at
// random; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module csv_field_splitter_tb;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_BYTES  = 38;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_idx   = csvs_pkg::CFG_FIELD_LIMIT;
    logic [15:0] i_cfg_data  = 16'd0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_line_byte = 8'd1;
    logic        i_line_last = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_field_index;
    logic [7:0]  o_field_count;
    logic        o_last;

    int   fail_count;
    int   pending;
    int   tx_idle_pct = 14;
    int   rx_idle_pct = 47;
    int   hold_left   = 0;
    int   quiet       = 0;
    int   bytes_sent  = 0;
    logic rx_hold_go  = 1'b0;

    always #1 i_clk = ~i_clk;

    csv_field_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_line_byte   (i_line_byte),
        .i_line_last   (i_line_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_field_index (o_field_index),
        .o_field_count (o_field_count),
        .o_last        (o_last)
    );

    csv_split_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_line_byte   (i_line_byte),
        .i_line_last   (i_line_last),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_kind        (o_kind),
        .i_data_byte   (o_data_byte),
        .i_field_index (o_field_index),
        .i_field_count (o_field_count),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        i_stall <= rx_hold_go || hold_left != 0 || ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("csv_field_splitter_tb failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic line_last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_line_byte <= b;
        i_line_last <= line_last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_byte(s[k], k == s.len() - 1);
    endtask

    // hold until every expected word is in, then give a dropped byte time to pass
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] fields, input logic [15:0] budget);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= csvs_pkg::CFG_FIELD_LIMIT;
        i_cfg_data  <= {8'd0, fields};
        @(posedge i_clk);
        i_cfg_idx   <= csvs_pkg::CFG_BYTE_BUDGET;
        i_cfg_data  <= budget;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == csvs_pkg::CH_QUOTE || b == csvs_pkg::CH_COMMA);
        return b;
    endfunction

    task automatic send_random_line();
        logic [7:0] line_q[$];
        int n_fields, max_len, f, k, len, style, junk;
        n_fields = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36)
                                                : $urandom_range(1, 6);
        max_len  = (n_fields > 6) ? 1 : 5;
        for (f = 0; f < n_fields; f++) begin
            style = $urandom_range(0, 9);
            len   = $urandom_range(0, max_len);
            if (style < 5) begin
                // plain field; a quote past the first byte is just text
                for (k = 0; k < len; k++)
                    line_q.push_back((k > 0 && $urandom_range(0, 7) == 0) ?
                                     csvs_pkg::CH_QUOTE : text_byte());
            end else if (style < 9) begin
                line_q.push_back(csvs_pkg::CH_QUOTE);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            line_q.push_back(csvs_pkg::CH_QUOTE);
                            line_q.push_back(csvs_pkg::CH_QUOTE);
                        end
                        1: line_q.push_back(csvs_pkg::CH_COMMA);
                        default: line_q.push_back(text_byte());
                    endcase
                end
                // leave the last field's quote open now and then
                if (!(f == n_fields - 1 && $urandom_range(0, 7) == 0)) begin
                    line_q.push_back(csvs_pkg::CH_QUOTE);
                    junk = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                    for (k = 0; k < junk; k++)
                        line_q.push_back(text_byte());
                end
            end else begin
                for (k = 0; k <= len; k++)
                    line_q.push_back(8'($urandom_range(1, 255)));
            end
            if (f < n_fields - 1 || $urandom_range(0, 7) == 0)
                line_q.push_back(csvs_pkg::CH_COMMA);
        end
        if (line_q.size() == 0)
            line_q.push_back(text_byte());
        for (k = 0; k < line_q.size(); k++)
            send_byte(line_q[k], k == line_q.size() - 1);
        bytes_sent += line_q.size();
    endtask

    initial begin
        int ph;
        int target;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // quoted field with doubled quote and junk after the close, then plain
        send_text("\"a\"\"b\"x,c");
        send_text(",");
        // byte extremes and a trailing comma
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(csvs_pkg::CH_COMMA, 1'b1);
        // unclosed quote, then an empty quoted field ended by the line
        send_text("\"ab");
        send_text("\"\"");
        settle();
        cfg_write(8'd1, csvs_pkg::BYTE_BUDGET_RST);
        send_text("a,b");
        settle();
        cfg_write(8'd255, 16'd2);
        send_text("ab,c");

        for (ph = 0; ph < 9; ph++) begin
            settle();
            case (ph / 3)
                0: begin
                    tx_idle_pct  = 14;
                    rx_idle_pct <= 47;
                end
                1: begin
                    tx_idle_pct  = 47;
                    rx_idle_pct <= 14;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            case (ph)
                0: cfg_write(csvs_pkg::FIELD_LIMIT_RST, csvs_pkg::BYTE_BUDGET_RST);
                1: cfg_write(8'd3, 16'($urandom_range(8, 24)));
                2: cfg_write(8'd255, 16'd65535);
                3: cfg_write(8'd1, 16'($urandom_range(2, 65535)));
                4: cfg_write(8'($urandom_range(1, 8)), 16'd2);
                5: cfg_write(8'($urandom_range(1, 255)), 16'($urandom_range(2, 40)));
                6: cfg_write(csvs_pkg::FIELD_LIMIT_RST, csvs_pkg::BYTE_BUDGET_RST);
                7: cfg_write(8'($urandom_range(2, 6)), 16'($urandom_range(6, 30)));
                default: cfg_write(8'($urandom_range(1, 255)),
                                   16'($urandom_range(2, 65535)));
            endcase
            if (ph == 6) begin
                // long receiver hold-off while bytes keep coming: fill the block
                rx_hold_go <= 1'b1;
                @(posedge i_clk);
                rx_hold_go <= 1'b0;
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                send_random_line();
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("csv_field_splitter_tb passed");
        else
            $display("csv_field_splitter_tb failed");
        $finish;
    end

endmodule
